// File: rtl/hft_pkg.sv
package hft_pkg;

  localparam int VALUE_BITS = 26;
  localparam int GAIN_BITS = 17;
  localparam int DIGIT_BITS = 8;
  localparam int CFG_INDEX_BITS = 1;

  localparam int VALUE_MAX = (1 << (VALUE_BITS - 1)) - 1;
  localparam int VALUE_MIN = -(1 << (VALUE_BITS - 1));

  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int COEF_FRAC_BITS_DEFAULT = 16;
  localparam int VALUE_FRAC_BITS_DEFAULT = 8;

  localparam logic [GAIN_BITS-1:0] LEVEL_GAIN_RESET = 17'd21787;
  localparam logic [GAIN_BITS-1:0] TREND_GAIN_RESET = 17'd65460;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_GAIN = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TREND_GAIN = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LMUL,
    ST_TLOAD,
    ST_TMUL,
    ST_FC
  } hft_state_t;

endpackage

// File: rtl/hft_sample_if.sv
interface hft_sample_if import hft_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_wh;

  modport source (output valid, output sample_wh, input ready);
  modport sink (input valid, input sample_wh, output ready);
endinterface

// File: rtl/hft_result_if.sv
interface hft_result_if import hft_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] forecast;
  logic                         was_first;

  modport source (output valid, output forecast, output was_first, input ready);
  modport sink (input valid, input forecast, input was_first, output ready);
endinterface

// File: rtl/hft_digit_mul.sv
module hft_digit_mul import hft_pkg::*; #(
  parameter int MCAND_BITS = VALUE_BITS + 2,
  parameter int MPLIER_BITS = 3 * DIGIT_BITS,
  localparam int PROD_BITS = MCAND_BITS + MPLIER_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [MCAND_BITS-1:0] mcand,
  input  logic [MPLIER_BITS-1:0]      mplier,
  output logic                        done,
  output logic signed [PROD_BITS-1:0] product
);

  localparam int NDIG = MPLIER_BITS / DIGIT_BITS;
  localparam int CNT_BITS = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic signed [MCAND_BITS-1:0]          mc;
  logic [MPLIER_BITS-1:0]                mreg;
  logic signed [PROD_BITS-1:0]           acc;
  logic [CNT_BITS-1:0]                   cnt;
  logic                                  running;
  logic signed [MCAND_BITS+DIGIT_BITS:0] term;

  // The multiplier is consumed one digit per cycle, most significant digit first.
  assign term = mc * $signed({1'b0, mreg[MPLIER_BITS-1 -: DIGIT_BITS]});
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(NDIG - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc <= mcand;
      mreg <= mplier;
      acc <= '0;
    end else if (running) begin
      acc <= (acc <<< DIGIT_BITS) + PROD_BITS'(term);
      mreg <= mreg << DIGIT_BITS;
    end
  end

endmodule

// File: rtl/holt_trend_forecast.sv
// Holt linear-trend forecaster for periodic energy samples.
// The sample channel carries one unsigned sample_wh per transfer; the result
// channel returns one transfer per sample with a signed Q.VALUE_FRAC_BITS
// forecast and a was_first flag. Gains are to be written on the configuration
// port (index 0 level gain, index 1 trend gain, both Q0.COEF_FRAC_BITS) while
// idle; the block itself does not enforce this. The first sample after reset
// loads the level, clears the trend and returns the sample through ST_FC and
// the output register, with was_first set. Every later sample runs two
// updates through one digit-serial multiplier that takes the gain as NDIG =
// ceil((COEF_FRAC_BITS + 1) / 8) digits of 8 bits: ST_LMUL updates the level,
// ST_TLOAD starts the trend product, ST_TMUL updates the trend and ST_FC loads
// the forecast into the output register; a new sample is taken only in ST_IDLE.
// The output register holds a finished result while the receiver stalls; the
// next sample is taken meanwhile and its result waits in the block until the
// output register frees.
// Reset clears the level, the trend and the started flag, empties the output
// register and restores the default gains.
module holt_trend_forecast import hft_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT,
  parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  hft_sample_if.sink                sample,
  hft_result_if.source              result,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [GAIN_BITS-1:0]      cfg_data
);

  localparam int COEF_ONE = 1 << COEF_FRAC_BITS;
  localparam int EFF_BITS = COEF_FRAC_BITS + 1;
  localparam int NDIG = (EFF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int MPW = NDIG * DIGIT_BITS;
  localparam int GCW = (GAIN_BITS > EFF_BITS) ? GAIN_BITS : EFF_BITS;
  localparam int DIFF_BITS = VALUE_BITS + 2;
  localparam int PROD_BITS = DIFF_BITS + MPW + 1;
  localparam int SH_BITS = PROD_BITS - COEF_FRAC_BITS;
  localparam int SUM_BITS = SH_BITS + 2;
  localparam int XW = SAMPLE_BITS + VALUE_FRAC_BITS;
  localparam int XCW = (XW > VALUE_BITS) ? XW : VALUE_BITS;

  hft_state_t state, state_next;

  logic signed [VALUE_BITS-1:0] level;
  logic signed [VALUE_BITS-1:0] slope;
  logic signed [VALUE_BITS-1:0] prev;
  logic                         started;
  logic                         first;
  logic [GAIN_BITS-1:0]         level_gain;
  logic [GAIN_BITS-1:0]         trend_gain;

  logic                         out_valid;
  logic signed [VALUE_BITS-1:0] out_forecast;
  logic                         out_first;

  logic                         accept;
  logic                         out_free;
  logic [XCW-1:0]               scaled;
  logic signed [VALUE_BITS-1:0] x;
  logic [GAIN_BITS-1:0]         gsel;
  logic [GCW-1:0]               gcmp;
  logic [GCW-1:0]               geff;
  logic signed [DIFF_BITS-1:0]  mcand;
  logic [MPW-1:0]               mplier;
  logic                         mul_start;
  logic                         mul_done;
  logic signed [PROD_BITS-1:0]  product;
  logic signed [SH_BITS-1:0]    psh;
  logic signed [SUM_BITS-1:0]   sat_in;
  logic signed [VALUE_BITS-1:0] sat_out;

  hft_digit_mul #(
    .MCAND_BITS  (DIFF_BITS),
    .MPLIER_BITS (MPW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mcand),
    .mplier  (mplier),
    .done    (mul_done),
    .product (product)
  );

  assign accept = sample.valid & sample.ready;
  assign out_free = !out_valid | result.ready;

  assign result.valid = out_valid;
  assign result.forecast = out_forecast;
  assign result.was_first = out_first;

  assign scaled = XCW'(sample.sample_wh) << VALUE_FRAC_BITS;
  assign x = (scaled > XCW'(VALUE_MAX)) ? VALUE_BITS'(VALUE_MAX) : scaled[VALUE_BITS-1:0];

  // A gain above one is used as exactly one.
  assign gsel = (state == ST_TLOAD) ? trend_gain : level_gain;
  assign gcmp = GCW'(gsel);
  assign geff = (gcmp > GCW'(COEF_ONE)) ? GCW'(COEF_ONE) : gcmp;
  assign mplier = MPW'(geff);

  // Each update is base + floor(gain * (target - base) / one).
  assign psh = product[PROD_BITS-1:COEF_FRAC_BITS];

  assign sat_out = (sat_in > SUM_BITS'(VALUE_MAX)) ? VALUE_BITS'(VALUE_MAX) :
                   (sat_in < SUM_BITS'(VALUE_MIN)) ? VALUE_BITS'(VALUE_MIN) :
                   sat_in[VALUE_BITS-1:0];

  always_comb begin
    case (state)
      ST_TLOAD: mcand = DIFF_BITS'(level) - DIFF_BITS'(prev) - DIFF_BITS'(slope);
      default:  mcand = DIFF_BITS'(x) - DIFF_BITS'(level) - DIFF_BITS'(slope);
    endcase
  end

  always_comb begin
    case (state)
      ST_LMUL: sat_in = SUM_BITS'(level) + SUM_BITS'(slope) + SUM_BITS'(psh);
      ST_TMUL: sat_in = SUM_BITS'(slope) + SUM_BITS'(psh);
      default: sat_in = SUM_BITS'(level) + SUM_BITS'(slope);
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = started ? ST_LMUL : ST_FC;
        end
      end
      ST_LMUL: begin
        if (mul_done) begin
          state_next = ST_TLOAD;
        end
      end
      ST_TLOAD: state_next = ST_TMUL;
      ST_TMUL: begin
        if (mul_done) begin
          state_next = ST_FC;
        end
      end
      ST_FC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = 1'b0;
    mul_start = 1'b0;
    case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        mul_start = sample.valid & started;
      end
      ST_TLOAD: mul_start = 1'b1;
      default: begin
        sample.ready = 1'b0;
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      started <= 1'b0;
      level <= '0;
      slope <= '0;
      level_gain <= LEVEL_GAIN_RESET;
      trend_gain <= TREND_GAIN_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_LEVEL_GAIN: level_gain <= cfg_data;
          REG_TREND_GAIN: trend_gain <= cfg_data;
          default: ;
        endcase
      end
      if (accept && !started) begin
        level <= x;
        slope <= '0;
        started <= 1'b1;
      end
      if (state == ST_LMUL && mul_done) begin
        level <= sat_out;
      end
      if (state == ST_TMUL && mul_done) begin
        slope <= sat_out;
      end
      if (state == ST_FC && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev <= level;
      first <= !started;
    end
    if (state == ST_FC && out_free) begin
      out_forecast <= sat_out;
      out_first <= first;
    end
  end

endmodule
